// ===== design/image_row_predictor_filter_top_assert.svh =====
// Assertion helpers shared by the modules of the row predictor filter.
// Both sample on clk and are disabled while rst_n is low.
`ifndef IMAGE_ROW_PREDICTOR_FILTER_TOP_ASSERT_SVH
`define IMAGE_ROW_PREDICTOR_FILTER_TOP_ASSERT_SVH

// Same-cycle implication.
`define IRPF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irpf assertion failed");

// Next-cycle implication.
`define IRPF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("irpf assertion failed");

`endif

// ===== design/irpf_pkg.sv =====
package irpf_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int PIX_W       = 8;
    localparam int MODE_W      = 3;
    localparam int DIM_REG_W   = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [MODE_W-1:0] MODE_NONE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUB2  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_UP    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_AVG   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_AVG2  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_PAETH = 3'd6;

    // Position class of one pixel, decided by the front end.
    typedef struct packed {
        logic first_row;
        logic first_col;
        logic frame_end;
    } ctl_t;

    localparam int CTL_W = $bits(ctl_t);

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] x,
                                                  input logic [PIX_W-1:0] y);
        logic [PIX_W:0] d;
        d = {1'b0, x} - {1'b0, y};
        abs_diff = d[PIX_W] ? PIX_W'(~d[PIX_W-1:0] + 1'b1) : d[PIX_W-1:0];
    endfunction

    // Paeth predictor with the estimate wrapped to 8 bits; ties prefer a, then b.
    function automatic logic [PIX_W-1:0] paeth_pick(input logic [PIX_W-1:0] a,
                                                    input logic [PIX_W-1:0] b,
                                                    input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] t;
        logic [PIX_W-1:0] pa;
        logic [PIX_W-1:0] pb;
        logic [PIX_W-1:0] pc;
        t  = a + b - c;
        pa = abs_diff(t, a);
        pb = abs_diff(t, b);
        pc = abs_diff(t, c);
        if (pa <= pb && pa <= pc)
        begin
            paeth_pick = a;
        end
        else if (pb <= pc)
        begin
            paeth_pick = b;
        end
        else
        begin
            paeth_pick = c;
        end
    endfunction

endpackage

// ===== design/irpf_front.sv =====
module irpf_front #(
    parameter int MAX_WIDTH  = irpf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = irpf_pkg::MAX_HEIGHT_DEF,
    parameter int CNT_W      = 12,
    parameter int RCNT_W     = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [irpf_pkg::DIM_REG_W-1:0]      image_width,
    input  logic [irpf_pkg::DIM_REG_W-1:0]      image_height,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                q_full,
    output logic                                q_push,
    output logic [CNT_W-1:0]                    q_col,
    output irpf_pkg::ctl_t                      q_ctl
);

    localparam int WCMP_W = (CNT_W + 1 > irpf_pkg::DIM_REG_W) ? CNT_W + 1
                                                               : irpf_pkg::DIM_REG_W;
    localparam int HCMP_W = (RCNT_W + 1 > irpf_pkg::DIM_REG_W) ? RCNT_W + 1
                                                                : irpf_pkg::DIM_REG_W;

    logic [CNT_W-1:0]  col_reg;
    logic [CNT_W-1:0]  col_next;
    logic [RCNT_W-1:0] row_reg;
    logic [RCNT_W-1:0] row_next;
    logic [WCMP_W-1:0] w_ext;
    logic [WCMP_W-1:0] w_eff;
    logic [WCMP_W-1:0] col_inc;
    logic [HCMP_W-1:0] h_ext;
    logic [HCMP_W-1:0] h_eff;
    logic [HCMP_W-1:0] row_inc;
    logic              last_col;
    logic              last_row;

    // Out-of-range dimensions fold to 1 or to MAX_WIDTH (the line store size) or MAX_HEIGHT.
    always_comb
    begin
        w_ext = WCMP_W'(image_width);
        h_ext = HCMP_W'(image_height);
        if (w_ext == '0)
        begin
            w_eff = WCMP_W'(1);
        end
        else if (w_ext > WCMP_W'(MAX_WIDTH))
        begin
            w_eff = WCMP_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_ext;
        end
        if (h_ext == '0)
        begin
            h_eff = HCMP_W'(1);
        end
        else if (h_ext > HCMP_W'(MAX_HEIGHT))
        begin
            h_eff = HCMP_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = h_ext;
        end
    end

    assign col_inc  = WCMP_W'(col_reg) + WCMP_W'(1);
    assign row_inc  = HCMP_W'(row_reg) + HCMP_W'(1);
    assign last_col = (col_inc >= w_eff);
    assign last_row = (row_inc >= h_eff);

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;
    assign q_col    = col_reg;

    always_comb
    begin
        q_ctl.first_row = (row_reg == '0);
        q_ctl.first_col = (col_reg == '0);
        q_ctl.frame_end = last_col && last_row;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (q_push)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_inc[RCNT_W-1:0];
            end
            else
            begin
                col_next = col_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

`include "image_row_predictor_filter_top_assert.svh"

    `IRPF_ASSERT_NXT(a_frame_wraps, q_push && q_ctl.frame_end, col_reg == '0 && row_reg == '0)

endmodule

// ===== design/irpf_queue.sv =====
module irpf_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic         empty,
    output logic [W-1:0] rdata
);

    localparam int DEPTH = irpf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`include "image_row_predictor_filter_top_assert.svh"

    `IRPF_ASSERT_IMP(a_no_pop_empty, pop, !empty)
    `IRPF_ASSERT_NXT(a_pop_drains, pop && !push, count_reg == $past(count_reg) - 1'b1)

endmodule

// ===== design/irpf_back.sv =====
module irpf_back #(
    parameter int MAX_WIDTH = irpf_pkg::MAX_WIDTH_DEF,
    parameter int CNT_W     = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [irpf_pkg::MODE_W-1:0]     filter_mode,
    input  logic                            q_empty,
    output logic                            q_pop,
    input  logic [irpf_pkg::PIX_W-1:0]      q_pixel,
    input  logic [CNT_W-1:0]                q_col,
    input  irpf_pkg::ctl_t                  q_ctl,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [irpf_pkg::PIX_W-1:0]      residual,
    output logic                            frame_end
);

    localparam int PW = irpf_pkg::PIX_W;

    logic [PW-1:0]  line_mem [MAX_WIDTH];
    logic [PW-1:0]  above_reg;
    logic           s1_valid_reg;
    logic           s1_valid_next;
    logic [PW-1:0]  s1_pixel_reg;
    irpf_pkg::ctl_t s1_ctl_reg;
    logic [PW-1:0]  left_reg;
    logic [PW-1:0]  upleft_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [PW-1:0]  out_res_reg;
    logic           out_last_reg;
    logic           stall;
    logic           s1_adv;
    logic [PW-1:0]  pred;
    logic [PW:0]    ab_sum;

    assign stall  = out_valid_reg && !out_ready;
    assign s1_adv = s1_valid_reg && !stall;
    assign q_pop  = !q_empty && (!s1_valid_reg || !stall);

    // Read-before-write: the same transfer fetches the pixel above and
    // stores its own pixel in that column, so a one-pixel-wide image needs
    // no bypass.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            above_reg       <= line_mem[q_col];
            line_mem[q_col] <= q_pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_pixel_reg <= q_pixel;
            s1_ctl_reg   <= q_ctl;
        end
        if (s1_adv)
        begin
            out_res_reg  <= s1_pixel_reg - pred;
            out_last_reg <= s1_ctl_reg.frame_end;
        end
    end

    assign ab_sum = {1'b0, left_reg} + {1'b0, above_reg};

    always_comb
    begin
        pred = '0;
        case (filter_mode)
            irpf_pkg::MODE_SUB:
            begin
                pred = s1_ctl_reg.first_col ? '0 : left_reg;
            end
            irpf_pkg::MODE_SUB2:
            begin
                if (s1_ctl_reg.first_col)
                begin
                    pred = s1_ctl_reg.first_row ? '0 : above_reg;
                end
                else
                begin
                    pred = left_reg;
                end
            end
            irpf_pkg::MODE_UP:
            begin
                pred = s1_ctl_reg.first_row ? '0 : above_reg;
            end
            irpf_pkg::MODE_AVG, irpf_pkg::MODE_AVG2:
            begin
                if (s1_ctl_reg.first_row)
                begin
                    pred = s1_ctl_reg.first_col ? '0 : (left_reg >> 1);
                end
                else if (s1_ctl_reg.first_col)
                begin
                    pred = above_reg >> 1;
                end
                else if (filter_mode == irpf_pkg::MODE_AVG)
                begin
                    pred = ab_sum[PW:1];
                end
                else
                begin
                    pred = left_reg + above_reg - upleft_reg;
                end
            end
            irpf_pkg::MODE_PAETH:
            begin
                if (s1_ctl_reg.first_row)
                begin
                    pred = s1_ctl_reg.first_col ? '0 : left_reg;
                end
                else if (s1_ctl_reg.first_col)
                begin
                    pred = above_reg;
                end
                else
                begin
                    pred = irpf_pkg::paeth_pick(left_reg, above_reg, upleft_reg);
                end
            end
            default:
            begin
                pred = '0;
            end
        endcase
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (q_pop)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
            upleft_reg    <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                left_reg   <= s1_pixel_reg;
                upleft_reg <= above_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign residual  = out_res_reg;
    assign frame_end = out_last_reg;

`include "image_row_predictor_filter_top_assert.svh"

    `IRPF_ASSERT_NXT(a_pop_loads_s1, q_pop, s1_valid_reg)
    `IRPF_ASSERT_NXT(a_adv_fills_out, s1_adv, out_valid_reg)

endmodule

// ===== design/image_row_predictor_filter_top.sv =====
// A pixel passes the queue, line store read and output register. Throughput: one pixel per
// cycle while the output is not stalled; the line store is read and written once per pixel
// through a single port, and a four-entry queue decouples the position counters from it.
// Reset (rst_n low, asynchronous) clears the counters, queue, pipeline valids and the
// left/upper-left pixels; mode resets to none, width and height to 1.
// The line store has no reset: every entry is written one row before it is read.
module image_row_predictor_filter_top #(
    parameter int MAX_WIDTH  = irpf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = irpf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [irpf_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [irpf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [7:0] pixel_value
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata,  // [7:0] residual
    output logic                                m_axis_tlast   // frame_end
);

    localparam int CNT_W  = $clog2(MAX_WIDTH);
    localparam int RCNT_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PW     = irpf_pkg::PIX_W;
    localparam int CW     = irpf_pkg::CTL_W;
    localparam int QW     = PW + CW + CNT_W;

    logic [irpf_pkg::MODE_W-1:0]    mode_reg;
    logic [irpf_pkg::DIM_REG_W-1:0] width_reg;
    logic [irpf_pkg::DIM_REG_W-1:0] height_reg;

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_empty;
    logic [CNT_W-1:0] f_col;
    irpf_pkg::ctl_t f_ctl;
    logic [QW-1:0]  q_wdata;
    logic [QW-1:0]  q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= irpf_pkg::MODE_NONE;
            width_reg  <= irpf_pkg::DIM_REG_W'(1);
            height_reg <= irpf_pkg::DIM_REG_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                irpf_pkg::REG_MODE:   mode_reg   <= cfg_wdata[irpf_pkg::MODE_W-1:0];
                irpf_pkg::REG_WIDTH:  width_reg  <= cfg_wdata[irpf_pkg::DIM_REG_W-1:0];
                irpf_pkg::REG_HEIGHT: height_reg <= cfg_wdata[irpf_pkg::DIM_REG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    irpf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CNT_W      (CNT_W),
        .RCNT_W     (RCNT_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (width_reg),
        .image_height (height_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_col        (f_col),
        .q_ctl        (f_ctl)
    );

    assign q_wdata = {f_col, f_ctl, s_axis_tdata[PW-1:0]};

    irpf_queue #(
        .W (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    irpf_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .CNT_W     (CNT_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .filter_mode (mode_reg),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .q_pixel     (q_rdata[PW-1:0]),
        .q_col       (q_rdata[QW-1:PW+CW]),
        .q_ctl       (irpf_pkg::ctl_t'(q_rdata[PW+CW-1:PW])),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .residual    (m_axis_tdata),
        .frame_end   (m_axis_tlast)
    );

endmodule

// ===== tb/sv/tb_image_row_predictor_filter_top.sv =====
module tb_image_row_predictor_filter_top;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int IDLE_PCT      = 24;
    localparam int STALL_CYCLES  = 400;
    localparam int PIPE_DRAIN    = 8;
    localparam int RANDOM_PIXELS = 1350;

    // Codes the package leaves unnamed: the spare mode value and the spare register slot.
    localparam logic [irpf_pkg::MODE_W-1:0]    MODE_SPARE = 3'd7;
    localparam logic [irpf_pkg::CFG_IDX_W-1:0] REG_SPARE  = 2'd3;

    typedef enum int {TEX_NOISE, TEX_BINARY, TEX_GRAIN, TEX_RAMP} texture_t;

    typedef struct packed {
        logic [irpf_pkg::PIX_W-1:0] residual;
        logic                       frame_end;
    } residual_t;

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            cfg_we        = 1'b0;
    logic [irpf_pkg::CFG_IDX_W-1:0]  cfg_idx       = '0;
    logic [irpf_pkg::CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [7:0]                      m_axis_tdata;
    logic                            m_axis_tlast;

    logic [irpf_pkg::PIX_W-1:0] pending_pixels[$];
    residual_t                  expected_residuals[$];

    // Predictor state and its copy of the registers.
    logic [irpf_pkg::PIX_W-1:0]     prev_row [0:irpf_pkg::MAX_WIDTH_DEF-1];
    logic [irpf_pkg::PIX_W-1:0]     left_px    = '0;
    logic [irpf_pkg::PIX_W-1:0]     upleft_px  = '0;
    int                             col_pos    = 0;
    int                             row_pos    = 0;
    logic [irpf_pkg::MODE_W-1:0]    mode_sel   = irpf_pkg::MODE_NONE;
    logic [irpf_pkg::DIM_REG_W-1:0] width_sel  = 13'd1;
    logic [irpf_pkg::DIM_REG_W-1:0] height_sel = 13'd1;

    int        src_idle_pct = IDLE_PCT;
    int        snk_idle_pct = IDLE_PCT;
    bit        stall_req    = 1'b0;
    int        stall_left   = 0;
    bit        pixel_taken  = 1'b0;
    int        fail_cnt     = 0;
    int        cycle_cnt    = 0;
    residual_t fresh_res;
    residual_t oldest_res;

    image_row_predictor_filter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    function automatic int eff_dim(input logic [irpf_pkg::DIM_REG_W-1:0] v, input int limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return limit;
        return v;
    endfunction

    task automatic predict_residual(input logic [irpf_pkg::PIX_W-1:0] px,
                                    output residual_t res);
        int                         w;
        int                         h;
        logic [irpf_pkg::PIX_W-1:0] a;
        logic [irpf_pkg::PIX_W-1:0] b;
        logic [irpf_pkg::PIX_W-1:0] c;
        logic [irpf_pkg::PIX_W-1:0] t;
        logic [irpf_pkg::PIX_W-1:0] pred;
        int                         da;
        int                         db;
        int                         dc;
        bit                         first_row;
        bit                         first_col;
        bit                         last_col;
        bit                         last_row;
        w         = eff_dim(width_sel, irpf_pkg::MAX_WIDTH_DEF);
        h         = eff_dim(height_sel, irpf_pkg::MAX_HEIGHT_DEF);
        a         = left_px;
        b         = (col_pos < irpf_pkg::MAX_WIDTH_DEF) ? prev_row[col_pos] : '0;
        c         = upleft_px;
        first_row = (row_pos == 0);
        first_col = (col_pos == 0);
        last_col  = (col_pos + 1 >= w);
        last_row  = (row_pos + 1 >= h);
        pred      = '0;
        case (mode_sel)
            irpf_pkg::MODE_SUB:
                pred = first_col ? 8'd0 : a;
            irpf_pkg::MODE_SUB2:
                pred = first_col ? (first_row ? 8'd0 : b) : a;
            irpf_pkg::MODE_UP:
                pred = first_row ? 8'd0 : b;
            irpf_pkg::MODE_AVG, irpf_pkg::MODE_AVG2:
            begin
                if (first_row)
                    pred = first_col ? 8'd0 : (a >> 1);
                else if (first_col)
                    pred = b >> 1;
                else if (mode_sel == irpf_pkg::MODE_AVG)
                    pred = 8'(({1'b0, a} + {1'b0, b}) >> 1);
                else
                    pred = a + b - c;
            end
            irpf_pkg::MODE_PAETH:
            begin
                if (first_row)
                    pred = first_col ? 8'd0 : a;
                else if (first_col)
                    pred = b;
                else
                begin
                    // The estimate wraps to 8 bits before the distances are taken.
                    t  = a + b - c;
                    da = int'(t) - int'(a);
                    db = int'(t) - int'(b);
                    dc = int'(t) - int'(c);
                    da = (da < 0) ? -da : da;
                    db = (db < 0) ? -db : db;
                    dc = (dc < 0) ? -dc : dc;
                    if (da <= db && da <= dc)
                        pred = a;
                    else if (db <= dc)
                        pred = b;
                    else
                        pred = c;
                end
            end
            default:
                pred = '0;
        endcase
        res.residual  = px - pred;
        res.frame_end = last_col && last_row;
        upleft_px = b;
        if (col_pos < irpf_pkg::MAX_WIDTH_DEF)
            prev_row[col_pos] = px;
        left_px = px;
        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
    endtask

    // Pixel source: a new transfer is offered once the previous one has been taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || pixel_taken)
            begin
                if (pending_pixels.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_pixels.pop_front();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Residual sink, with an occasional long hold-off.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (stall_req)
            begin
                stall_left = STALL_CYCLES;
                stall_req  = 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left    = stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        pixel_taken = s_axis_tvalid && s_axis_tready;
        if (rst_n && pixel_taken)
        begin
            predict_residual(s_axis_tdata, fresh_res);
            expected_residuals.push_back(fresh_res);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_residuals.size() == 0)
            begin
                $error("residual transfer %0h (tlast %0b) with no prediction waiting",
                       m_axis_tdata, m_axis_tlast);
                fail_cnt++;
            end
            else
            begin
                oldest_res = expected_residuals.pop_front();
                if (m_axis_tdata !== oldest_res.residual)
                begin
                    $error("residual mismatch: expected %0h, got %0h",
                           oldest_res.residual, m_axis_tdata);
                    fail_cnt++;
                end
                if (m_axis_tlast !== oldest_res.frame_end)
                begin
                    $error("frame_end mismatch: expected %0b, got %0b",
                           oldest_res.frame_end, m_axis_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic wait_idle;
        @(negedge clk);
        while (pending_pixels.size() != 0 || s_axis_tvalid || expected_residuals.size() != 0)
            @(negedge clk);
        repeat (PIPE_DRAIN) @(negedge clk);
    endtask

    task automatic write_reg(input logic [irpf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [irpf_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        case (idx)
            irpf_pkg::REG_MODE:   mode_sel   = val[irpf_pkg::MODE_W-1:0];
            irpf_pkg::REG_WIDTH:  width_sel  = val;
            irpf_pkg::REG_HEIGHT: height_sel = val;
            default:              ;
        endcase
    endtask

    // Only called between whole images, so the counters are back at the first pixel.
    task automatic configure(input logic [irpf_pkg::MODE_W-1:0] mode_val,
                             input logic [irpf_pkg::DIM_REG_W-1:0] width_val,
                             input logic [irpf_pkg::DIM_REG_W-1:0] height_val);
        wait_idle();
        // Bits above the mode field are don't-care, so they get random values.
        write_reg(irpf_pkg::REG_MODE, {10'($urandom), mode_val});
        write_reg(irpf_pkg::REG_WIDTH, width_val);
        write_reg(irpf_pkg::REG_HEIGHT, height_val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_images(input int n_img, inout int pushed);
        int                         npx;
        texture_t                   tex;
        logic [irpf_pkg::PIX_W-1:0] base;
        logic [irpf_pkg::PIX_W-1:0] px;
        npx = eff_dim(width_sel, irpf_pkg::MAX_WIDTH_DEF) *
              eff_dim(height_sel, irpf_pkg::MAX_HEIGHT_DEF);
        repeat (n_img)
        begin
            tex  = texture_t'($urandom_range(TEX_NOISE, TEX_RAMP));
            base = 8'($urandom);
            for (int i = 0; i < npx; i++)
            begin
                case (tex)
                    TEX_NOISE:  px = 8'($urandom);
                    TEX_BINARY: px = $urandom_range(1) ? 8'hFF : 8'h00;
                    // Small noise around one level gives many equal neighbours.
                    TEX_GRAIN:  px = base + 8'($urandom_range(4)) - 8'd2;
                    default:    px = base + 8'(i * 3);
                endcase
                pending_pixels.push_back(px);
            end
            pushed += npx;
        end
    endtask

    initial
    begin
        int                             random_px;
        int                             other_px;
        int                             sel;
        logic [irpf_pkg::DIM_REG_W-1:0] wv;
        logic [irpf_pkg::DIM_REG_W-1:0] hv;
        random_px = 0;
        other_px  = 0;
        foreach (prev_row[i])
            prev_row[i] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(REG_SPARE, 13'h1FFF);
        @(negedge clk);
        cfg_we <= 1'b0;

        // Zero sizes act as one: every pixel is a whole image.
        configure(irpf_pkg::MODE_NONE, 13'd0, 13'd0);
        pending_pixels.push_back(8'h00);
        pending_pixels.push_back(8'hFF);
        for (int m = irpf_pkg::MODE_SUB; m <= irpf_pkg::MODE_PAETH; m++)
        begin
            configure(3'(m), 13'd2, 13'd2);
            pending_pixels.push_back(8'h00);
            pending_pixels.push_back(8'hFF);
            pending_pixels.push_back(8'hFF);
            pending_pixels.push_back(8'h80);
        end
        configure(MODE_SPARE, 13'd0, 13'd0);
        pending_pixels.push_back(8'h5A);

        // The sink holds off while the source keeps offering, so the input backs up.
        configure(irpf_pkg::MODE_PAETH, 13'd16, 13'd8);
        stall_req = 1'b1;
        queue_images(2, other_px);

        configure(3'($urandom_range(irpf_pkg::MODE_SUB, MODE_SPARE)), 13'd32, 13'd8);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        queue_images(1, other_px);

        while (random_px < RANDOM_PIXELS)
        begin
            sel = $urandom_range(99);
            wv  = (sel < 5)  ? 13'd0 :
                  (sel < 75) ? 13'($urandom_range(1, 8)) : 13'($urandom_range(9, 48));
            sel = $urandom_range(99);
            hv  = (sel < 5) ? 13'd0 : 13'($urandom_range(1, 6));
            configure(3'($urandom_range(irpf_pkg::MODE_NONE, MODE_SPARE)), wv, hv);
            src_idle_pct = IDLE_PCT;
            snk_idle_pct = IDLE_PCT;
            queue_images($urandom_range(1, 3), random_px);
        end

        wait_idle();
        repeat (16) @(negedge clk);
        if (fail_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/irpf_pkg.sv
design/irpf_front.sv
design/irpf_queue.sv
design/irpf_back.sv
design/image_row_predictor_filter_top.sv
tb/sv/tb_image_row_predictor_filter_top.sv
